[rtl/assert_macros.svh]
// assertion macros for the filter rtl
// expects signals clock and reset in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define KF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/kf_pkg.sv]
// types, memory map, step table and helpers for the kalman filter engine
// no dependencies
`default_nettype none
package kf_pkg;
   localparam int STATE_DIM = 4;
   localparam int MEAS_DIM  = 2;
   localparam int DW        = 32;
   localparam int FRAC      = 16;
   localparam int ACC_W     = 52;
   localparam int OPB_W     = DW + 1;
   localparam int PROD_W    = DW + OPB_W;
   localparam int NUM_W     = DW + FRAC;

   localparam int X_BASE  = 0;
   localparam int P_BASE  = X_BASE + STATE_DIM;
   localparam int F_BASE  = P_BASE + STATE_DIM * STATE_DIM;
   localparam int H_BASE  = F_BASE + STATE_DIM * STATE_DIM;
   localparam int R_BASE  = H_BASE + MEAS_DIM * STATE_DIM;
   localparam int Q_BASE  = R_BASE + MEAS_DIM * MEAS_DIM;
   localparam int T1_BASE = Q_BASE + STATE_DIM * STATE_DIM;
   localparam int T2_BASE = T1_BASE + STATE_DIM * STATE_DIM;
   localparam int B_BASE  = T2_BASE + STATE_DIM * STATE_DIM;
   localparam int K_BASE  = B_BASE + STATE_DIM * MEAS_DIM;
   localparam int Y_BASE  = K_BASE + STATE_DIM * MEAS_DIM;
   localparam int S_BASE  = Y_BASE + MEAS_DIM;
   localparam int NX_BASE = S_BASE + MEAS_DIM * MEAS_DIM;
   localparam int MEM_DEPTH = NX_BASE + STATE_DIM;
   localparam int AW = $clog2(MEM_DEPTH);
   localparam int SW = AW + 2;
   localparam int CW = $clog2(STATE_DIM + 1);

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_PREDICT = 2'd1;
   localparam logic [1:0] KIND_UPDATE  = 2'd2;
   localparam logic [1:0] KIND_READ    = 2'd3;

   localparam logic [2:0] SEL_STATE = 3'd0;
   localparam logic [2:0] SEL_COV   = 3'd1;
   localparam logic [2:0] SEL_TRANS = 3'd2;
   localparam logic [2:0] SEL_HMAP  = 3'd3;
   localparam logic [2:0] SEL_RNOISE = 3'd4;
   localparam logic [2:0] SEL_QNOISE = 3'd5;

   localparam logic [1:0] OP_MAC = 2'd0;
   localparam logic [1:0] OP_DET = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;
   localparam logic [1:0] OP_END = 2'd3;

   localparam logic [1:0] INIT_ZERO = 2'd0;
   localparam logic [1:0] INIT_MEM  = 2'd1;
   localparam logic [1:0] INIT_EYE  = 2'd2;
   localparam logic [1:0] INIT_Z    = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic [2:0]           matrix_sel;
      logic [1:0]           row;
      logic [1:0]           col;
      logic signed [DW-1:0] value;
      logic signed [DW-1:0] z_first;
      logic signed [DW-1:0] z_second;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] read_value;
      logic                 singular;
      logic                 saturated;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic accum;
      logic sub;
   } mac_ctl_type;

   typedef struct packed {
      logic                 clip;
      logic signed [DW-1:0] val;
   } sat_type;

   typedef struct packed {
      logic          ok;
      logic [AW-1:0] addr;
   } loc_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [CW-1:0]        ni;
      logic [CW-1:0]        nj;
      logic [CW-1:0]        nk;
      logic signed [SW-1:0] a_base;
      logic signed [SW-1:0] a_si;
      logic signed [SW-1:0] a_sk;
      logic signed [SW-1:0] b_base;
      logic signed [SW-1:0] b_sk;
      logic signed [SW-1:0] b_sj;
      logic [1:0]           init;
      logic signed [SW-1:0] c_base;
      logic signed [SW-1:0] c_si;
      logic signed [SW-1:0] c_sj;
      logic signed [SW-1:0] d_base;
      logic signed [SW-1:0] d_si;
      logic signed [SW-1:0] d_sj;
      logic                 sub;
      logic                 neg_off;
      logic                 alt_sign;
   } step_type;

   function automatic sat_type sat32(input logic signed [ACC_W-1:0] v);
      sat_type s;
      if (v[ACC_W-1:DW-1] == '0 || v[ACC_W-1:DW-1] == '1) begin
         s.clip = 1'b0;
         s.val  = v[DW-1:0];
      end else begin
         s.clip = 1'b1;
         s.val  = v[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
      return s;
   endfunction

   function automatic loc_type locate(input logic [2:0] sel, input logic [1:0] row,
                                      input logic [1:0] col);
      loc_type l;
      int r;
      int c;
      int a;
      logic ok;
      r  = int'(row);
      c  = int'(col);
      a  = 0;
      ok = 1'b0;
      case (sel)
         SEL_STATE: begin
            ok = (r < STATE_DIM) && (c == 0);
            a  = X_BASE + r;
         end
         SEL_COV: begin
            ok = (r < STATE_DIM) && (c < STATE_DIM);
            a  = P_BASE + r * STATE_DIM + c;
         end
         SEL_TRANS: begin
            ok = (r < STATE_DIM) && (c < STATE_DIM);
            a  = F_BASE + r * STATE_DIM + c;
         end
         SEL_HMAP: begin
            ok = (r < MEAS_DIM) && (c < STATE_DIM);
            a  = H_BASE + r * STATE_DIM + c;
         end
         SEL_RNOISE: begin
            ok = (r < MEAS_DIM) && (c < MEAS_DIM);
            a  = R_BASE + r * MEAS_DIM + c;
         end
         SEL_QNOISE: begin
            ok = (r < STATE_DIM) && (c < STATE_DIM);
            a  = Q_BASE + r * STATE_DIM + c;
         end
         default: ok = 1'b0;
      endcase
      l.ok   = ok;
      l.addr = a[AW-1:0];
      return l;
   endfunction

   function automatic step_type mk(input logic [1:0] op, input int ni, input int nj,
                                   input int nk, input int ab, input int asi, input int ask,
                                   input int bb, input int bsk, input int bsj,
                                   input logic [1:0] init, input int cb, input int csi,
                                   input int csj, input int db, input int dsi, input int dsj,
                                   input logic sub, input logic neg_off, input logic alt);
      step_type s;
      s.op       = op;
      s.ni       = CW'(ni);
      s.nj       = CW'(nj);
      s.nk       = CW'(nk);
      s.a_base   = SW'(ab);
      s.a_si     = SW'(asi);
      s.a_sk     = SW'(ask);
      s.b_base   = SW'(bb);
      s.b_sk     = SW'(bsk);
      s.b_sj     = SW'(bsj);
      s.init     = init;
      s.c_base   = SW'(cb);
      s.c_si     = SW'(csi);
      s.c_sj     = SW'(csj);
      s.d_base   = SW'(db);
      s.d_si     = SW'(dsi);
      s.d_sj     = SW'(dsj);
      s.sub      = sub;
      s.neg_off  = neg_off;
      s.alt_sign = alt;
      return s;
   endfunction

   // step program for predict and update
   function automatic step_type step_rom(input logic upd, input logic [3:0] idx);
      localparam int N = STATE_DIM;
      localparam int M = MEAS_DIM;
      step_type s;
      s = mk(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, INIT_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      if (!upd) begin
         case (idx)
            4'd0: s = mk(OP_MAC, N, 1, N, F_BASE, N, 1, X_BASE, 1, 0,
                         INIT_ZERO, 0, 0, 0, NX_BASE, 1, 0, 0, 0, 0);
            4'd1: s = mk(OP_MAC, N, N, N, F_BASE, N, 1, P_BASE, N, 1,
                         INIT_ZERO, 0, 0, 0, T1_BASE, N, 1, 0, 0, 0);
            4'd2: s = mk(OP_MAC, N, N, N, T1_BASE, N, 1, F_BASE, 1, N,
                         INIT_MEM, Q_BASE, N, 1, P_BASE, N, 1, 0, 0, 0);
            4'd3: s = mk(OP_MAC, N, 1, 0, 0, 0, 0, 0, 0, 0,
                         INIT_MEM, NX_BASE, 1, 0, X_BASE, 1, 0, 0, 0, 0);
            default: ;
         endcase
      end else begin
         case (idx)
            4'd0: s = mk(OP_MAC, M, 1, N, H_BASE, N, 1, X_BASE, 1, 0,
                         INIT_Z, 0, 0, 0, Y_BASE, 1, 0, 1, 0, 0);
            4'd1: s = mk(OP_MAC, N, M, N, P_BASE, N, 1, H_BASE, 1, N,
                         INIT_ZERO, 0, 0, 0, B_BASE, M, 1, 0, 0, 0);
            4'd2: s = mk(OP_MAC, M, M, N, H_BASE, N, 1, B_BASE, M, 1,
                         INIT_MEM, R_BASE, M, 1, S_BASE, M, 1, 0, 0, 0);
            4'd3: begin
               if (M == 2)
                  s = mk(OP_DET, 1, 1, 2, S_BASE, 0, 1, S_BASE + 3, -1, 0,
                         INIT_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 1);
               else
                  s = mk(OP_DET, 1, 1, 0, 0, 0, 0, 0, 0, 0,
                         INIT_MEM, S_BASE, 0, 0, 0, 0, 0, 0, 0, 0);
            end
            4'd4: begin
               if (M == 2)
                  s = mk(OP_MAC, N, M, M, B_BASE, M, 1, S_BASE + 3, -1, -2,
                         INIT_ZERO, 0, 0, 0, K_BASE, M, 1, 0, 1, 0);
               else
                  s = mk(OP_MAC, N, 1, 0, 0, 0, 0, 0, 0, 0,
                         INIT_MEM, B_BASE, 1, 0, K_BASE, 1, 0, 0, 0, 0);
            end
            4'd5: s = mk(OP_DIV, N, M, 0, 0, 0, 0, 0, 0, 0,
                         INIT_ZERO, 0, 0, 0, K_BASE, M, 1, 0, 0, 0);
            4'd6: s = mk(OP_MAC, N, 1, M, K_BASE, M, 1, Y_BASE, 1, 0,
                         INIT_MEM, X_BASE, 1, 0, X_BASE, 1, 0, 0, 0, 0);
            4'd7: s = mk(OP_MAC, N, N, M, K_BASE, M, 1, H_BASE, N, 1,
                         INIT_EYE, 0, 0, 0, T1_BASE, N, 1, 1, 0, 0);
            4'd8: s = mk(OP_MAC, N, N, N, T1_BASE, N, 1, P_BASE, N, 1,
                         INIT_ZERO, 0, 0, 0, T2_BASE, N, 1, 0, 0, 0);
            4'd9: s = mk(OP_MAC, N, N, 0, 0, 0, 0, 0, 0, 0,
                         INIT_MEM, T2_BASE, N, 1, P_BASE, N, 1, 0, 0, 0);
            default: ;
         endcase
      end
      return s;
   endfunction
endpackage
`default_nettype wire

[rtl/kf_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module kf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[rtl/kf_mac.sv]
// shared multiply, round and accumulate unit, q16.16 products
// depends on kf_pkg
`default_nettype none
module kf_mac (
   input  logic                               clock,
   input  kf_pkg::mac_ctl_type                ctl,
   input  logic signed [kf_pkg::ACC_W-1:0]    init_val,
   input  logic signed [kf_pkg::DW-1:0]       op_a,
   input  logic signed [kf_pkg::OPB_W-1:0]    op_b,
   output logic signed [kf_pkg::ACC_W-1:0]    acc,
   output kf_pkg::sat_type                    acc_sat
);
   import kf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] biased;
   logic signed [PROD_W-1:0] rounded;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_ff;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   assign biased  = prod_ff + PROD_W'(1 << (FRAC - 1));
   assign rounded = biased >>> FRAC;
   assign term    = rounded[ACC_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctl.load) begin
         acc_ff <= init_val;
      end else if (ctl.accum) begin
         acc_ff <= ctl.sub ? acc_ff - term : acc_ff + term;
      end
   end

   assign acc     = acc_ff;
   assign acc_sat = sat32(acc_ff);
endmodule
`default_nettype wire

[rtl/kf_div.sv]
// iterative restoring divider, (num * 2^16) / den truncated toward zero
// depends on kf_pkg
`default_nettype none
module kf_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [kf_pkg::DW-1:0]    num,
   input  logic signed [kf_pkg::ACC_W-1:0] den,
   output logic                            busy,
   output logic                            done,
   output kf_pkg::sat_type                 quot
);
   import kf_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] dmag_ff, dmag_in;
   logic             neg_ff, neg_in;
   logic [ACC_W:0]   trial;
   logic [DW-1:0]    nmag;
   logic signed [ACC_W-1:0] qs;

   assign nmag  = num[DW-1] ? DW'(-num) : num;
   assign trial = {rem_ff, n_ff[NUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = {nmag, {FRAC{1'b0}}};
         q_in    = '0;
         rem_in  = '0;
         dmag_in = den[ACC_W-1] ? ACC_W'(-den) : den;
         neg_in  = num[DW-1] ^ den[ACC_W-1];
      end else if (busy_ff) begin
         n_in = {n_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = ACC_W'(trial - {1'b0, dmag_ff});
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ACC_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign qs   = neg_ff ? -ACC_W'(q_ff) : ACC_W'(q_ff);
   assign quot = sat32(qs);
   assign busy = busy_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

[rtl/linear_kalman_filter.sv]
// linear kalman filter engine top: step sequencer, element ram, mac and divider
// depends on kf_pkg, kf_ram, kf_mac, kf_div and assert_macros.svh
//
//   port group  dir  handshake            beat
//   req_        in   req_valid/req_stall  one command (write, predict, update, read)
//   rsp_        out  rsp_valid/rsp_stall  read value and flags, one per command
//
// write goes through the done state, read through rdwait and done; predict and update run
// a step program on one shared multiplier, each step through the step state, each product
// through ra, rb, mul and acc, each result element through init, initw and wb, and each
// gain element of update through drd, dld and a divide in dwait; new commands wait for idle
// reset is synchronous and clears control only; stored matrices are undefined
// until written. a waiting result holds the sequencer in its final state
`default_nettype none
module linear_kalman_filter (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  kf_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output kf_pkg::rsp_type rsp_data
);
   import kf_pkg::*;
`include "assert_macros.svh"

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RDWAIT = 4'd1;
   localparam logic [3:0] ST_DONE   = 4'd2;
   localparam logic [3:0] ST_STEP   = 4'd3;
   localparam logic [3:0] ST_INIT   = 4'd4;
   localparam logic [3:0] ST_INITW  = 4'd5;
   localparam logic [3:0] ST_RA     = 4'd6;
   localparam logic [3:0] ST_RB     = 4'd7;
   localparam logic [3:0] ST_MUL    = 4'd8;
   localparam logic [3:0] ST_ACC    = 4'd9;
   localparam logic [3:0] ST_WB     = 4'd10;
   localparam logic [3:0] ST_DRD    = 4'd11;
   localparam logic [3:0] ST_DLD    = 4'd12;
   localparam logic [3:0] ST_DWAIT  = 4'd13;

   logic [3:0]              state_ff, state_in;
   logic [3:0]              step_ff, step_in;
   logic [CW-1:0]           i_ff, i_in;
   logic [CW-1:0]           j_ff, j_in;
   logic [CW-1:0]           k_ff, k_in;
   logic [1:0]              kind_ff, kind_in;
   logic signed [DW-1:0]    z0_ff, z0_in;
   logic signed [DW-1:0]    z1_ff, z1_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic signed [DW-1:0]    rd_ff, rd_in;
   logic signed [DW-1:0]    opa_ff, opa_in;
   logic signed [ACC_W-1:0] det_ff, det_in;
   logic                    sing_ff, sing_in;
   logic                    clip_ff, clip_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   step_type                st;
   loc_type                 loc;
   logic                    accept;
   logic                    last_elem;
   logic                    last_j;
   int                      a_sum, b_sum, c_sum, d_sum;
   logic [AW-1:0]           a_addr, b_addr, c_addr, d_addr;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   logic [DW-1:0]           ram_wdata, ram_rdata;

   mac_ctl_type             mac_ctl;
   logic signed [ACC_W-1:0] mac_init;
   logic signed [OPB_W-1:0] mac_b;
   logic signed [ACC_W-1:0] mac_acc;
   sat_type                 mac_sat;

   logic                    div_start, div_busy, div_done;
   sat_type                 div_q;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign st        = step_rom(kind_ff == KIND_UPDATE, step_ff);
   assign loc       = locate(req_data.matrix_sel, req_data.row, req_data.col);
   assign last_j    = (j_ff == st.nj - 1'b1);
   assign last_elem = last_j && (i_ff == st.ni - 1'b1);

   always_comb begin
      a_sum  = int'(st.a_base) + int'(i_ff) * int'(st.a_si) + int'(k_ff) * int'(st.a_sk);
      b_sum  = int'(st.b_base) + int'(k_ff) * int'(st.b_sk) + int'(j_ff) * int'(st.b_sj);
      c_sum  = int'(st.c_base) + int'(i_ff) * int'(st.c_si) + int'(j_ff) * int'(st.c_sj);
      d_sum  = int'(st.d_base) + int'(i_ff) * int'(st.d_si) + int'(j_ff) * int'(st.d_sj);
      a_addr = a_sum[AW-1:0];
      b_addr = b_sum[AW-1:0];
      c_addr = c_sum[AW-1:0];
      d_addr = d_sum[AW-1:0];
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: ram_raddr = loc.addr;
         ST_INIT: ram_raddr = c_addr;
         ST_RA:   ram_raddr = a_addr;
         ST_RB:   ram_raddr = b_addr;
         ST_DRD:  ram_raddr = d_addr;
         default: ram_raddr = '0;
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = d_addr;
      ram_wdata = mac_sat.val;
      if (state_ff == ST_IDLE) begin
         ram_we    = accept && (req_data.kind == KIND_WRITE) && loc.ok;
         ram_waddr = loc.addr;
         ram_wdata = req_data.value;
      end else if (state_ff == ST_WB) begin
         ram_we = (st.op == OP_MAC);
      end else if (state_ff == ST_DWAIT) begin
         ram_we    = div_done;
         ram_wdata = div_q.val;
      end
   end

   always_comb begin
      mac_ctl.load  = (state_ff == ST_INITW);
      mac_ctl.mul   = (state_ff == ST_MUL);
      mac_ctl.accum = (state_ff == ST_ACC);
      mac_ctl.sub   = st.sub ^ (st.alt_sign & k_ff[0]);
      mac_b         = OPB_W'(signed'(ram_rdata));
      if (st.neg_off && (k_ff != j_ff)) begin
         mac_b = -mac_b;
      end
      case (st.init)
         INIT_MEM:  mac_init = ACC_W'(signed'(ram_rdata));
         INIT_EYE:  mac_init = (i_ff == j_ff) ? ACC_W'(1 << FRAC) : '0;
         INIT_Z:    mac_init = (i_ff == '0) ? ACC_W'(z0_ff) : ACC_W'(z1_ff);
         default:   mac_init = '0;
      endcase
   end

   assign div_start = (state_ff == ST_DLD);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      kind_in      = kind_ff;
      z0_in        = z0_ff;
      z1_in        = z1_ff;
      rd_ok_in     = rd_ok_ff;
      rd_in        = rd_ff;
      opa_in       = opa_ff;
      det_in       = det_ff;
      sing_in      = sing_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_data.kind;
               z0_in    = req_data.z_first;
               z1_in    = req_data.z_second;
               rd_ok_in = loc.ok;
               rd_in    = '0;
               sing_in  = 1'b0;
               clip_in  = 1'b0;
               step_in  = '0;
               case (req_data.kind)
                  KIND_READ:  state_in = ST_RDWAIT;
                  KIND_WRITE: state_in = ST_DONE;
                  default:    state_in = ST_STEP;
               endcase
            end
         end
         ST_RDWAIT: begin
            rd_in    = rd_ok_ff ? signed'(ram_rdata) : '0;
            state_in = ST_DONE;
         end
         ST_STEP: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            case (st.op)
               OP_END:  state_in = ST_DONE;
               OP_DIV:  state_in = ST_DRD;
               default: state_in = ST_INIT;
            endcase
         end
         ST_INIT: state_in = ST_INITW;
         ST_INITW: begin
            k_in     = '0;
            state_in = (st.nk == '0) ? ST_WB : ST_RA;
         end
         ST_RA: state_in = ST_RB;
         ST_RB: begin
            opa_in   = signed'(ram_rdata);
            state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (k_ff == st.nk - 1'b1) begin
               state_in = ST_WB;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_RA;
            end
         end
         ST_WB: begin
            if (st.op == OP_DET) begin
               det_in = mac_acc;
               if (mac_acc == '0) begin
                  sing_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_STEP;
               end
            end else begin
               clip_in = clip_ff | mac_sat.clip;
               if (last_elem) begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_INIT;
                  if (last_j) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         ST_DRD: state_in = ST_DLD;
         ST_DLD: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_done) begin
               clip_in = clip_ff | div_q.clip;
               if (last_elem) begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_DRD;
                  if (last_j) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_value = (kind_ff == KIND_READ) ? rd_ff : '0;
               rsp_in.singular   = sing_ff;
               rsp_in.saturated  = clip_ff;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff  <= step_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      kind_ff  <= kind_in;
      z0_ff    <= z0_in;
      z1_ff    <= z1_in;
      rd_ok_ff <= rd_ok_in;
      rd_ff    <= rd_in;
      opa_ff   <= opa_in;
      det_ff   <= det_in;
      sing_ff  <= sing_in;
      clip_ff  <= clip_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   kf_ram #(
      .WIDTH (DW),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   kf_mac u_mac (
      .clock    (clock),
      .ctl      (mac_ctl),
      .init_val (mac_init),
      .op_a     (opa_ff),
      .op_b     (mac_b),
      .acc      (mac_acc),
      .acc_sat  (mac_sat)
   );

   kf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (signed'(ram_rdata)),
      .den   (det_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   `KF_ASSERT_NXT(a_busy_after_accept, accept, req_stall)
   `KF_ASSERT_IMP(a_div_nonzero_den, (state_ff == ST_DWAIT) && div_done, det_ff != '0)
   `KF_ASSERT_IMP(a_div_idle, state_ff == ST_IDLE, !div_busy)
endmodule
`default_nettype wire

[dv/tb_linear_kalman_filter.sv]
// self-checking testbench for linear_kalman_filter: queued command beats,
// an in-order prediction of each response, bursty sender and stalling receiver
// depends on kf_pkg and the rtl of linear_kalman_filter
`timescale 1ns / 1ps
`default_nettype none
module tb_linear_kalman_filter;
   import kf_pkg::*;

   localparam int N          = STATE_DIM;
   localparam int M          = MEAS_DIM;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_LEN   = 3000;
   localparam int NUM_ITEMS  = 450;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   linear_kalman_filter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   req_type cmd_q[$];
   rsp_type rsp_exp_q[$];

   // filter copy
   int  xs[N];
   int  pm[N*N];
   int  fm[N*N];
   int  hm[M*N];
   int  rm[M*M];
   int  qm[N*N];
   bit  clip_flag;

   int  errors;
   int  mismatches;
   int  n_sent;
   int  n_recv;
   int  n_predict;
   int  n_update;
   int  n_singular;
   int  n_saturated;
   int  idle_cycles;

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   function automatic int sat(input longint v);
      if (v > 64'sd2147483647) begin
         clip_flag = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         clip_flag = 1'b1;
         return 32'sh80000000;
      end
      return int'(v);
   endfunction

   task automatic kf_predict();
      int     nx[N];
      int     fp[N*N];
      int     np[N*N];
      longint acc;
      for (int i = 0; i < N; i++) begin
         acc = 0;
         for (int k = 0; k < N; k++) acc += qmul(fm[i*N+k], xs[k]);
         nx[i] = sat(acc);
      end
      for (int i = 0; i < N; i++)
         for (int j = 0; j < N; j++) begin
            acc = 0;
            for (int k = 0; k < N; k++) acc += qmul(fm[i*N+k], pm[k*N+j]);
            fp[i*N+j] = sat(acc);
         end
      for (int i = 0; i < N; i++)
         for (int j = 0; j < N; j++) begin
            acc = qm[i*N+j];
            for (int k = 0; k < N; k++) acc += qmul(fp[i*N+k], fm[j*N+k]);
            np[i*N+j] = sat(acc);
         end
      xs = nx;
      pm = np;
   endtask

   task automatic kf_update(input int z0, input int z1, output bit sing);
      int     y[2];
      int     s[4];
      int     b[N*2];
      int     kg[N*2];
      int     cm[N*N];
      int     np[N*N];
      longint adj[4];
      longint det;
      longint acc;
      longint num;
      sing = 1'b0;
      for (int m = 0; m < M; m++) begin
         acc = (m == 0) ? z0 : z1;
         for (int k = 0; k < N; k++) acc -= qmul(hm[m*N+k], xs[k]);
         y[m] = sat(acc);
      end
      for (int i = 0; i < N; i++)
         for (int m = 0; m < M; m++) begin
            acc = 0;
            for (int k = 0; k < N; k++) acc += qmul(pm[i*N+k], hm[m*N+k]);
            b[i*2+m] = sat(acc);
         end
      for (int i = 0; i < M; i++)
         for (int j = 0; j < M; j++) begin
            acc = rm[i*M+j];
            for (int k = 0; k < N; k++) acc += qmul(hm[i*N+k], b[k*2+j]);
            s[i*2+j] = sat(acc);
         end
      if (M == 2) begin
         det = qmul(s[0], s[3]) - qmul(s[1], s[2]);
         adj[0] = s[3];
         adj[1] = -longint'(s[1]);
         adj[2] = -longint'(s[2]);
         adj[3] = s[0];
      end else begin
         det = s[0];
         adj[0] = 65536;
         adj[1] = 0;
         adj[2] = 0;
         adj[3] = 0;
      end
      if (det == 0) begin
         sing = 1'b1;
         return;
      end
      for (int i = 0; i < N; i++)
         for (int m = 0; m < M; m++) begin
            if (M == 2) begin
               acc = 0;
               for (int k = 0; k < 2; k++) acc += qmul(b[i*2+k], adj[k*2+m]);
               num = sat(acc);
            end else begin
               num = b[i*2];
            end
            kg[i*2+m] = sat((num * 64'sd65536) / det);
         end
      for (int i = 0; i < N; i++) begin
         acc = xs[i];
         for (int m = 0; m < M; m++) acc += qmul(kg[i*2+m], y[m]);
         xs[i] = sat(acc);
      end
      for (int i = 0; i < N; i++)
         for (int j = 0; j < N; j++) begin
            acc = (i == j) ? 65536 : 0;
            for (int m = 0; m < M; m++) acc -= qmul(kg[i*2+m], hm[m*N+j]);
            cm[i*N+j] = sat(acc);
         end
      for (int i = 0; i < N; i++)
         for (int j = 0; j < N; j++) begin
            acc = 0;
            for (int k = 0; k < N; k++) acc += qmul(cm[i*N+k], pm[k*N+j]);
            np[i*N+j] = sat(acc);
         end
      pm = np;
   endtask

   task automatic kf_element(input req_type t, input bit wr, output int rd);
      int r;
      int c;
      r  = t.row;
      c  = t.col;
      rd = 0;
      case (t.matrix_sel)
         SEL_STATE:
            if (r < N && c == 0) begin
               if (wr) xs[r] = t.value; else rd = xs[r];
            end
         SEL_COV:
            if (r < N && c < N) begin
               if (wr) pm[r*N+c] = t.value; else rd = pm[r*N+c];
            end
         SEL_TRANS:
            if (r < N && c < N) begin
               if (wr) fm[r*N+c] = t.value; else rd = fm[r*N+c];
            end
         SEL_HMAP:
            if (r < M && c < N) begin
               if (wr) hm[r*N+c] = t.value; else rd = hm[r*N+c];
            end
         SEL_RNOISE:
            if (r < M && c < M) begin
               if (wr) rm[r*M+c] = t.value; else rd = rm[r*M+c];
            end
         SEL_QNOISE:
            if (r < N && c < N) begin
               if (wr) qm[r*N+c] = t.value; else rd = qm[r*N+c];
            end
         default: ;
      endcase
   endtask

   task automatic kf_step(input req_type t);
      rsp_type e;
      int      rd;
      bit      sing;
      clip_flag = 1'b0;
      rd        = 0;
      sing      = 1'b0;
      case (t.kind)
         KIND_WRITE:   kf_element(t, 1'b1, rd);
         KIND_PREDICT: begin
            kf_predict();
            n_predict++;
         end
         KIND_UPDATE: begin
            kf_update(t.z_first, t.z_second, sing);
            n_update++;
         end
         default:      kf_element(t, 1'b0, rd);
      endcase
      if (t.kind != KIND_WRITE) rd = (t.kind == KIND_READ) ? rd : 0;
      e.read_value = rd;
      e.singular   = sing;
      e.saturated  = clip_flag;
      if (sing) n_singular++;
      if (clip_flag) n_saturated++;
      rsp_exp_q.push_back(e);
   endtask

   task automatic add_cmd(input logic [1:0] kind, input logic [2:0] sel, input int row,
                          input int col, input int value, input int z0, input int z1);
      req_type t;
      t.kind       = kind;
      t.matrix_sel = sel;
      t.row        = row[1:0];
      t.col        = col[1:0];
      t.value      = value;
      t.z_first    = z0;
      t.z_second   = z1;
      cmd_q.push_back(t);
   endtask

   function automatic int small_q();
      return int'($urandom_range(131072)) - 65536;
   endfunction

   // well-conditioned model: f near identity, positive diagonal p and r, non-negative diagonal q
   task automatic load_model();
      for (int i = 0; i < N; i++) add_cmd(KIND_WRITE, SEL_STATE, i, 0, small_q() * 4, 0, 0);
      for (int i = 0; i < N; i++)
         for (int j = 0; j < N; j++) begin
            add_cmd(KIND_WRITE, SEL_COV, i, j,
                    (i == j) ? 65536 + int'($urandom_range(65536)) : small_q() / 8, 0, 0);
            add_cmd(KIND_WRITE, SEL_TRANS, i, j,
                    (i == j) ? 65536 : small_q() / 4, 0, 0);
            add_cmd(KIND_WRITE, SEL_QNOISE, i, j,
                    (i == j) ? int'($urandom_range(8192)) : 0, 0, 0);
         end
      for (int i = 0; i < M; i++)
         for (int j = 0; j < N; j++)
            add_cmd(KIND_WRITE, SEL_HMAP, i, j, (i == j) ? 65536 : small_q() / 4, 0, 0);
      for (int i = 0; i < M; i++)
         for (int j = 0; j < M; j++)
            add_cmd(KIND_WRITE, SEL_RNOISE, i, j,
                    (i == j) ? 16384 + int'($urandom_range(65536)) : 0, 0, 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // driver
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            kf_step(req_data);
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
               req_data  <= cmd_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(20, 1);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern with one long hold-off
   int  stall_mode;
   int  mode_left;
   int  hold_left;
   bit  hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
         mode_left  <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else begin
         if (!hold_done && n_recv == 120) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(2);
               mode_left  = $urandom_range(300, 20);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(9) < 3);
               default: rsp_stall <= ($urandom_range(9) < 8);
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_recv++;
         if (rsp_exp_q.size() == 0) begin
            errors++;
            $display("unexpected response beat %0d: %h", n_recv, rsp_data);
         end else begin
            e = rsp_exp_q.pop_front();
            if (e.read_value !== rsp_data.read_value || e.singular !== rsp_data.singular ||
                e.saturated !== rsp_data.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d mismatch: exp value %h sing %b sat %b, got %h %b %b",
                           n_recv, e.read_value, e.singular, e.saturated,
                           rsp_data.read_value, rsp_data.singular, rsp_data.saturated);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d responses outstanding", rsp_exp_q.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      int r;
      int c;
      int sel;
      errors      = 0;
      mismatches  = 0;
      n_sent      = 0;
      n_recv      = 0;
      n_predict   = 0;
      n_update    = 0;
      n_singular  = 0;
      n_saturated = 0;
      reset       = 1'b1;

      // directed
      load_model();
      add_cmd(KIND_READ, SEL_STATE, 0, 0, 0, 0, 0);
      add_cmd(KIND_WRITE, SEL_QNOISE, 3, 3, 32'sh7fffffff, 0, 0);
      add_cmd(KIND_READ, SEL_QNOISE, 3, 3, 0, 0, 0);
      add_cmd(KIND_WRITE, SEL_QNOISE, 3, 3, 32'sh80000000, 0, 0);
      add_cmd(KIND_READ, SEL_QNOISE, 3, 3, 0, 0, 0);
      add_cmd(KIND_WRITE, SEL_QNOISE, 3, 3, 0, 0, 0);
      add_cmd(KIND_WRITE, SEL_HMAP, 3, 1, 12345, 0, 0);
      add_cmd(KIND_READ, SEL_HMAP, 3, 1, 0, 0, 0);
      add_cmd(KIND_WRITE, SEL_RNOISE, 1, 2, 12345, 0, 0);
      add_cmd(KIND_READ, SEL_RNOISE, 2, 0, 0, 0, 0);
      add_cmd(KIND_WRITE, SEL_STATE, 1, 2, 777, 0, 0);
      add_cmd(KIND_READ, SEL_STATE, 1, 3, 0, 0, 0);
      add_cmd(KIND_WRITE, 3'd6, 0, 0, 999, 0, 0);
      add_cmd(KIND_READ, 3'd7, 1, 1, 0, 0, 0);
      add_cmd(KIND_PREDICT, SEL_STATE, 0, 0, 0, 0, 0);
      add_cmd(KIND_UPDATE, SEL_STATE, 0, 0, 0, 65536, -65536);
      add_cmd(KIND_UPDATE, SEL_STATE, 0, 0, 0, 32'sh7fffffff, 32'sh80000000);
      add_cmd(KIND_READ, SEL_COV, 0, 0, 0, 0, 0);
      // zero h and r give a singular innovation
      for (int i = 0; i < M; i++) begin
         for (int j = 0; j < N; j++) add_cmd(KIND_WRITE, SEL_HMAP, i, j, 0, 0, 0);
         for (int j = 0; j < M; j++) add_cmd(KIND_WRITE, SEL_RNOISE, i, j, 0, 0, 0);
      end
      add_cmd(KIND_UPDATE, SEL_STATE, 0, 0, 0, 32'sh80000000, 32'sh7fffffff);
      // huge transition forces clipping on predict
      add_cmd(KIND_WRITE, SEL_TRANS, 0, 0, 32'sh7fffffff, 0, 0);
      add_cmd(KIND_WRITE, SEL_TRANS, 0, 1, 32'sh80000000, 0, 0);
      add_cmd(KIND_PREDICT, SEL_STATE, 0, 0, 0, 0, 0);
      add_cmd(KIND_READ, SEL_STATE, 0, 0, 0, 0, 0);
      load_model();

      // random
      while (cmd_q.size() < NUM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            sel = $urandom_range(7);
            r   = $urandom_range(3);
            c   = $urandom_range(3);
            add_cmd(KIND_WRITE, sel[2:0], r, c,
                    ($urandom_range(9) == 0) ? int'($urandom) : small_q(), 0, 0);
         end else if (pick < 45) begin
            add_cmd(KIND_PREDICT, 3'($urandom_range(7)), $urandom_range(3), $urandom_range(3),
                    int'($urandom), int'($urandom), int'($urandom));
         end else if (pick < 70) begin
            if ($urandom_range(9) == 0)
               add_cmd(KIND_UPDATE, 3'($urandom_range(7)), $urandom_range(3),
                       $urandom_range(3), int'($urandom), int'($urandom), int'($urandom));
            else
               add_cmd(KIND_UPDATE, SEL_STATE, 0, 0, 0, small_q() * 4, small_q() * 4);
         end else begin
            add_cmd(KIND_READ, 3'($urandom_range(7)), $urandom_range(3), $urandom_range(3),
                    int'($urandom), int'($urandom), int'($urandom));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (cmd_q.size() != 0 || req_valid || rsp_exp_q.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);

      $display("%0d commands, %0d predicts, %0d updates (%0d singular), %0d clipping",
               n_sent, n_predict, n_update, n_singular, n_saturated);
      $display("%0d responses checked, %0d mismatches, %0d unexpected",
               n_recv, mismatches, errors);
      if (errors == 0 && mismatches == 0 && rsp_exp_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
